// ===== src/gpf_pkg.sv =====
package gpf_pkg;

  // Default width of the value under test
  localparam int VALUE_BITS_DEFAULT = 16;

  // First odd candidate and first trial divisor
  localparam int FIRST_CAND = 3;
  localparam int FIRST_DIVISOR = 2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;          // latch the word, candidate back to three
    logic test_init;     // pick the number under test, divisor back to two
    logic test_partner;  // with test_init: test value minus candidate
    logic div_start;     // start a remainder on the current divisor
    logic step_divisor;  // move on to the next divisor
    logic next_cand;     // move on to the next odd candidate
    logic publish_found; // latch the pair as the result
    logic publish_none;  // latch a not-found result
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic value_odd;     // word under work is odd
    logic cand_below;    // candidate is below the word
    logic square_over;   // divisor squared exceeds the number under test
    logic rem_done;      // remainder is ready, one cycle
    logic rem_zero;      // divisor divides the number under test
  } status_t;

endpackage

// ===== src/gpf_rem_unit.sv =====
module gpf_rem_unit #(
  parameter int VALUE_BITS = gpf_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [VALUE_BITS-1:0] divisor,
  output logic                  done,
  output logic                  rem_zero
);

  localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

  logic                  running;
  logic [CNT_BITS-1:0]   count;
  logic [VALUE_BITS-1:0] rem;
  logic [VALUE_BITS-1:0] shifter;
  logic [VALUE_BITS:0]   trial;
  logic [VALUE_BITS:0]   trial_sub;
  logic                  fits;

  // One restoring step: bring down the next dividend bit, subtract if it fits
  assign trial     = {rem, shifter[VALUE_BITS-1]};
  assign fits      = trial >= {1'b0, divisor};
  assign trial_sub = trial - {1'b0, divisor};
  assign rem_zero  = (rem == '0);

  // Step counter and handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      count   <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= CNT_BITS'(VALUE_BITS);
      end else if (running) begin
        count <= count - 1'b1;
        if (count == CNT_BITS'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and dividend shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= '0;
      shifter <= dividend;
    end else if (running) begin
      rem     <= fits ? trial_sub[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
      shifter <= {shifter[VALUE_BITS-2:0], 1'b0};
    end
  end

endmodule

// ===== src/gpf_datapath.sv =====
module gpf_datapath #(
  parameter int VALUE_BITS = gpf_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [VALUE_BITS-1:0] even_value,
  input  gpf_pkg::cmd_t         cmd,
  output gpf_pkg::status_t      status,
  output logic                  found,
  output logic [VALUE_BITS-1:0] smaller_prime,
  output logic [VALUE_BITS-1:0] partner_prime
);

  localparam int SQ_BITS = VALUE_BITS + 2;

  logic [VALUE_BITS-1:0] value;
  logic [VALUE_BITS-1:0] cand;
  logic [VALUE_BITS-1:0] num;
  logic [VALUE_BITS-1:0] divisor;
  logic [SQ_BITS-1:0]    square;
  logic [VALUE_BITS-1:0] partner;
  logic                  rem_done;
  logic                  rem_zero;

  assign partner = value - cand;

  // Word, candidate, number under test, divisor and its square
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value <= even_value;
      cand  <= VALUE_BITS'(gpf_pkg::FIRST_CAND);
    end else if (cmd.next_cand) begin
      cand <= cand + VALUE_BITS'(2);
    end
    if (cmd.test_init) begin
      num     <= cmd.test_partner ? partner : cand;
      divisor <= VALUE_BITS'(gpf_pkg::FIRST_DIVISOR);
      square  <= SQ_BITS'(gpf_pkg::FIRST_DIVISOR * gpf_pkg::FIRST_DIVISOR);
    end else if (cmd.step_divisor) begin
      // (d+1)^2 = d^2 + 2d + 1
      divisor <= divisor + 1'b1;
      square  <= square + {1'b0, divisor, 1'b1};
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.publish_found) begin
      found         <= 1'b1;
      smaller_prime <= cand;
      partner_prime <= partner;
    end else if (cmd.publish_none) begin
      found         <= 1'b0;
      smaller_prime <= '0;
      partner_prime <= '0;
    end
  end

  gpf_rem_unit #(
    .VALUE_BITS(VALUE_BITS)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (num),
    .divisor  (divisor),
    .done     (rem_done),
    .rem_zero (rem_zero)
  );

  always_comb begin
    status.value_odd   = value[0];
    status.cand_below  = cand < value;
    status.square_over = square > {2'b00, num};
    status.rem_done    = rem_done;
    status.rem_zero    = rem_zero;
  end

endmodule

// ===== src/gpf_ctrl.sv =====
module gpf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  gpf_pkg::status_t status,
  output gpf_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             done
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_TEST  = 2'd2;
  localparam logic [1:0] S_DIV   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       on_partner;
  logic       on_partner_next;
  logic       done_next;

  assign busy = (state != S_IDLE);

  // Sequencing of candidates, tests and trial divisions
  always_comb begin
    state_next      = state;
    on_partner_next = on_partner;
    done_next       = 1'b0;
    cmd             = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.value_odd || !status.cand_below) begin
          cmd.publish_none = 1'b1;
          done_next        = 1'b1;
          state_next       = S_IDLE;
        end else begin
          cmd.test_init   = 1'b1;
          on_partner_next = 1'b0;
          state_next      = S_TEST;
        end
      end
      S_TEST: begin
        if (status.square_over) begin
          // number passed; test the partner or report the pair
          if (on_partner) begin
            cmd.publish_found = 1'b1;
            done_next         = 1'b1;
            state_next        = S_IDLE;
          end else begin
            cmd.test_init    = 1'b1;
            cmd.test_partner = 1'b1;
            on_partner_next  = 1'b1;
          end
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (status.rem_done) begin
          if (status.rem_zero) begin
            cmd.next_cand = 1'b1;
            state_next    = S_CHECK;
          end else begin
            cmd.step_divisor = 1'b1;
            state_next       = S_TEST;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      on_partner <= 1'b0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      on_partner <= on_partner_next;
      done       <= done_next;
    end
  end

endmodule

// ===== src/goldbach_prime_pair_finder.sv =====
// Channel  Handshake            Ports
// -------  -------------------  ----------------------------------------------
// input    start, busy          even_value
// result   done (one cycle)     found, smaller_prime, partner_prime
//
// One word at a time. Each trial divisor is one run of the bit-serial
// remainder unit; each candidate first passes through a check state, and each
// candidate that passes trial division is followed by a test of its partner.
// Odd words, 0 and 2 report not found from the check state, with no division.
// rst is synchronous; results hold until the next one; the receiver cannot stall.
module goldbach_prime_pair_finder #(
  parameter int VALUE_BITS = gpf_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] even_value,
  output logic                  done,
  output logic                  found,
  output logic [VALUE_BITS-1:0] smaller_prime,
  output logic [VALUE_BITS-1:0] partner_prime
);

  gpf_pkg::cmd_t    cmd;
  gpf_pkg::status_t status;

  gpf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  gpf_datapath #(
    .VALUE_BITS(VALUE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .even_value    (even_value),
    .cmd           (cmd),
    .status        (status),
    .found         (found),
    .smaller_prime (smaller_prime),
    .partner_prime (partner_prime)
  );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int W = gpf_pkg::VALUE_BITS_DEFAULT;
  localparam int RANDOM_WORDS = 120;
  // Watchdog bound on the whole run, far above what the slowest words need
  localparam longint CYCLE_LIMIT = 20_000_000;
  // Margin waited after the last expected result has been checked
  localparam int DRAIN_CYCLES = 64;

  // Expected answer for one word
  typedef struct packed {
    logic         found;
    logic [W-1:0] smaller;
    logic [W-1:0] partner;
  } split_t;

  // Directed row: word, whether the answer is typed in, and that answer
  typedef struct packed {
    logic [W-1:0] value;
    bit           typed;
    split_t       want;
  } row_t;

  localparam int DIRECTED_ROWS = 20;

  logic         clk;
  logic         rst;
  logic         start;
  logic         busy;
  logic [W-1:0] even_value;
  logic         done;
  logic         found;
  logic [W-1:0] smaller_prime;
  logic [W-1:0] partner_prime;

  split_t pending_splits[$];
  int     error_count;
  longint cycle_count;

  row_t directed_rows [0:DIRECTED_ROWS-1] = '{
    '{16'd0,     1'b1, '{1'b0, 16'd0, 16'd0}},
    '{16'd2,     1'b1, '{1'b0, 16'd0, 16'd0}},
    '{16'd1,     1'b1, '{1'b0, 16'd0, 16'd0}},
    '{16'd3,     1'b1, '{1'b0, 16'd0, 16'd0}},
    '{16'd65535, 1'b1, '{1'b0, 16'd0, 16'd0}},
    '{16'd21845, 1'b1, '{1'b0, 16'd0, 16'd0}},
    '{16'd4,     1'b1, '{1'b1, 16'd3, 16'd1}},
    '{16'd6,     1'b1, '{1'b1, 16'd3, 16'd3}},
    '{16'd8,     1'b1, '{1'b1, 16'd3, 16'd5}},
    '{16'd10,    1'b0, '0},
    '{16'd12,    1'b0, '0},
    '{16'd100,   1'b0, '0},
    '{16'd128,   1'b0, '0},
    '{16'd1000,  1'b0, '0},
    '{16'd65534, 1'b0, '0},
    '{16'd65532, 1'b0, '0},
    '{16'd32768, 1'b0, '0},
    '{16'd43690, 1'b0, '0},
    '{16'd32766, 1'b0, '0},
    '{16'd65533, 1'b1, '{1'b0, 16'd0, 16'd0}}
  };

  goldbach_prime_pair_finder #(
    .VALUE_BITS(W)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .even_value   (even_value),
    .done         (done),
    .found        (found),
    .smaller_prime(smaller_prime),
    .partner_prime(partner_prime)
  );

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Trial division: nothing from two up to the root divides n (0, 1, 2 pass)
  function automatic bit is_trial_prime(input int unsigned n);
    for (int unsigned d = gpf_pkg::FIRST_DIVISOR; d * d <= n; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // First odd candidate from three whose partner also passes
  function automatic split_t goldbach_split(input logic [W-1:0] v);
    split_t res;
    res = '0;
    if (v[0]) return res;
    for (int unsigned p = gpf_pkg::FIRST_CAND; p < v; p += 2) begin
      if (is_trial_prime(p) && is_trial_prime(v - p)) begin
        res.found   = 1'b1;
        res.smaller = p[W-1:0];
        res.partner = W'(v - p);
        return res;
      end
    end
    return res;
  endfunction

  // Random word: mostly small even sizes, some odd, a few across the full range
  function automatic logic [W-1:0] random_word();
    logic [W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1:    v = W'($urandom);
      2, 3, 4,
      5:       v = W'($urandom_range(0, 2047)) & ~W'(1);
      6, 7:    v = W'($urandom_range(0, 16383)) & ~W'(1);
      default: v = W'($urandom) & ~W'(1);
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned exp_v,
                                 input longint unsigned got_v);
    $display("[%0t] mismatch %s: expected %0d, got %0d", $time, what, exp_v, got_v);
    error_count++;
  endtask

  // Offer one word and wait until it is taken
  task automatic send_word(input logic [W-1:0] v, input bit typed, input split_t want);
    @(negedge clk);
    start      <= 1'b1;
    even_value <= v;
    do @(posedge clk); while (busy !== 1'b0);
    pending_splits.push_back(typed ? want : goldbach_split(v));
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      start      <= 1'b0;
      even_value <= W'($urandom);
    end
  endtask

  task automatic idle_gap();
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
    idle_cycles(gap);
  endtask

  // Result checker
  always @(posedge clk) begin
    split_t exp_s;
    if (!rst && done === 1'b1) begin
      if (pending_splits.size() == 0) begin
        report_mismatch("result words outstanding", 0, 1);
      end else begin
        exp_s = pending_splits.pop_front();
        if (found !== exp_s.found) report_mismatch("found", exp_s.found, found);
        if (smaller_prime !== exp_s.smaller)
          report_mismatch("smaller_prime", exp_s.smaller, smaller_prime);
        if (partner_prime !== exp_s.partner)
          report_mismatch("partner_prime", exp_s.partner, partner_prime);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int idx;
    int sent;
    int burst;
    error_count = 0;
    cycle_count = 0;
    rst         = 1'b1;
    start       = 1'b0;
    even_value  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table, walked in bursts
    idx = 0;
    while (idx < DIRECTED_ROWS) begin
      burst = $urandom_range(1, 4);
      for (int k = 0; k < burst && idx < DIRECTED_ROWS; k++) begin
        send_word(directed_rows[idx].value, directed_rows[idx].typed,
                  directed_rows[idx].want);
        idx++;
      end
      idle_gap();
    end

    // Random words, bursts of random length with random gaps
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      burst = $urandom_range(1, 8);
      for (int k = 0; k < burst && sent < RANDOM_WORDS; k++) begin
        send_word(random_word(), 1'b0, '0);
        sent++;
      end
      idle_gap();
    end
    idle_cycles(1);

    // Drain
    while (pending_splits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
